// ===== rtl/p2a_pkg.sv =====
// ----------------------------------------------------------------------------
// p2a_pkg
// shared types, constants and helpers of the ansi truecolor byte encoder
// ----------------------------------------------------------------------------
package p2a_pkg;

  localparam int unsigned MAX_LINE_PIXELS = 1024;
  localparam int unsigned MAX_FRAME_LINES = 1024;
  localparam int unsigned CFG_W           = 11;
  localparam int unsigned COL_W           = $clog2(MAX_LINE_PIXELS);
  localparam int unsigned ROW_W           = $clog2(MAX_FRAME_LINES);
  localparam int unsigned POS_W           = 5;

  // byte positions inside one pixel's text
  localparam logic [POS_W-1:0] POS_PIXEL_LAST = 5'd20;
  localparam logic [POS_W-1:0] POS_LINE_LAST  = 5'd25;

  // characters
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // register indexes
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_pixel;
    logic       end_of_frame;
  } txt_t;

  typedef struct packed {
    logic [CFG_W-1:0] line_width;
    logic [CFG_W-1:0] frame_height;
  } cfg_t;

  // one queued pixel: nine bcd digits, r hundreds first, b ones last
  typedef struct packed {
    logic            opaque;
    logic            line_end;
    logic            frame_end;
    logic [8:0][3:0] digits;
  } cmd_t;

  // exact floor(p / 255) for a product of two 8-bit values
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + 17'd1 + {9'b0, p[15:8]};
    return s[15:8];
  endfunction

  // three bcd digits of an 8-bit value, hundreds in the top nibble
  function automatic logic [11:0] to_bcd(input logic [7:0] q);
    logic [3:0]  h;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [7:0]  o;
    if (q >= 8'd200) begin
      h   = 4'd2;
      rem = q - 8'd200;
    end else if (q >= 8'd100) begin
      h   = 4'd1;
      rem = q - 8'd100;
    end else begin
      h   = 4'd0;
      rem = q;
    end
    prod = {8'b0, rem[6:0]} * 15'd205;
    t    = prod[14:11];
    o    = rem - {t, 3'b0} - {3'b0, t, 1'b0};
    return {h, t, o[3:0]};
  endfunction

endpackage

// ===== rtl/pixel_to_ansi_truecolor_bytes.sv =====
// ----------------------------------------------------------------------------
// pixel_to_ansi_truecolor_bytes
// rgba pixel stream to ansi truecolor terminal text, one byte per beat
// ----------------------------------------------------------------------------
// each accepted pixel turns into 21 output bytes (ESC[48;2;RRR;GGG;BBBm and
// two spaces, or ESC[ sixteen zeros m and two spaces when alpha is 0), and
// into 26 bytes on the last pixel of a line, where ESC[0m and a newline
// follow; on the last line of the frame a zero byte replaces the newline.
// colours are scaled as floor(c*alpha/255). the back part sends one byte per
// cycle unless out_ready holds the output register; a pixel passes the front
// product register, the queue and the back command and output registers. a
// two-entry queue sits between the pixel front end and the byte serializer,
// so pixels are taken while earlier ones are still being sent.
// line_width lies at address 0 and frame_height at address 4 (11 bits each,
// 0 acts as 1, values above 1024 act as 1024).
// ----------------------------------------------------------------------------
module pixel_to_ansi_truecolor_bytes import p2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_valid,
  output logic        in_ready,
  input  pix_t        in_data,
  // text output
  output logic        out_valid,
  input  logic        out_ready,
  output txt_t        out_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0] line_width_r, frame_height_r;
  logic             wr_en;
  cfg_t             cfg;

  // register write on the access phase
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= CFG_W'(80);
      frame_height_r <= CFG_W'(24);
    end else if (wr_en) begin
      case (paddr[2])
        REG_LINE_WIDTH:   line_width_r   <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (paddr[2])
      REG_LINE_WIDTH:   prdata = {{(32-CFG_W){1'b0}}, line_width_r};
      REG_FRAME_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, frame_height_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.line_width   = line_width_r;
  assign cfg.frame_height = frame_height_r;

  // front: pixel beats, position tracking, scaling, digit split
  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;

  p2a_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  // queue of per-pixel commands
  p2a_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  // back: byte serializer with output register
  p2a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/p2a_front.sv =====
// ----------------------------------------------------------------------------
// p2a_front
// accepts pixels, tracks line and frame position, scales and converts colours
// ----------------------------------------------------------------------------
module p2a_front import p2a_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  pix_t in_data,
  output logic push,
  output cmd_t push_cmd,
  input  logic full
);

  logic             s1_valid_r;
  logic [15:0]      pr_r, pg_r, pb_r;
  logic             opaque_r, line_end_r, frame_end_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CFG_W-1:0] w_eff, h_eff, col_inc, row_inc;
  logic             line_end, frame_end, accept;

  always_comb begin
    if (cfg.line_width == '0) w_eff = CFG_W'(1);
    else if (cfg.line_width > CFG_W'(MAX_LINE_PIXELS)) w_eff = CFG_W'(MAX_LINE_PIXELS);
    else w_eff = cfg.line_width;
    if (cfg.frame_height == '0) h_eff = CFG_W'(1);
    else if (cfg.frame_height > CFG_W'(MAX_FRAME_LINES)) h_eff = CFG_W'(MAX_FRAME_LINES);
    else h_eff = cfg.frame_height;
  end

  assign col_inc   = CFG_W'(col_r) + CFG_W'(1);
  assign row_inc   = CFG_W'(row_r) + CFG_W'(1);
  assign line_end  = col_inc >= w_eff;
  assign frame_end = line_end && (row_inc >= h_eff);

  assign push     = s1_valid_r && !full;
  assign in_ready = !s1_valid_r || !full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (line_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) s1_valid_r <= 1'b1;
      else if (push) s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pr_r        <= in_data.red   * in_data.alpha;
      pg_r        <= in_data.green * in_data.alpha;
      pb_r        <= in_data.blue  * in_data.alpha;
      opaque_r    <= in_data.alpha != 8'd0;
      line_end_r  <= line_end;
      frame_end_r <= frame_end;
    end
  end

  // second stage: divide by 255 and split into decimal digits
  logic [11:0] bcd_r, bcd_g, bcd_b;
  assign bcd_r = to_bcd(div255(pr_r));
  assign bcd_g = to_bcd(div255(pg_r));
  assign bcd_b = to_bcd(div255(pb_r));

  always_comb begin
    push_cmd.opaque    = opaque_r;
    push_cmd.line_end  = line_end_r;
    push_cmd.frame_end = frame_end_r;
    push_cmd.digits[0] = bcd_r[11:8];
    push_cmd.digits[1] = bcd_r[7:4];
    push_cmd.digits[2] = bcd_r[3:0];
    push_cmd.digits[3] = bcd_g[11:8];
    push_cmd.digits[4] = bcd_g[7:4];
    push_cmd.digits[5] = bcd_g[3:0];
    push_cmd.digits[6] = bcd_b[11:8];
    push_cmd.digits[7] = bcd_b[7:4];
    push_cmd.digits[8] = bcd_b[3:0];
  end

endmodule

// ===== rtl/p2a_fifo.sv =====
// ----------------------------------------------------------------------------
// p2a_fifo
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
module p2a_fifo import p2a_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_cmd = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/p2a_back.sv =====
// ----------------------------------------------------------------------------
// p2a_back
// serializes a queued pixel to text bytes, one beat per cycle unless stalled
// ----------------------------------------------------------------------------
module p2a_back import p2a_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic empty,
  input  cmd_t pop_cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output txt_t out_data
);

  logic             cur_valid_r;
  cmd_t             cmd_r;
  logic [POS_W-1:0] pos_r;
  logic             out_valid_r;
  txt_t             out_r;
  logic             out_free, emit, last;
  logic [POS_W-1:0] last_pos;
  logic [7:0]       ch;

  assign out_free = !out_valid_r || out_ready;
  assign emit     = cur_valid_r && out_free;
  assign last_pos = cmd_r.line_end ? POS_LINE_LAST : POS_PIXEL_LAST;
  assign last     = pos_r == last_pos;
  assign pop      = !empty && (!cur_valid_r || (emit && last));

  function automatic logic [7:0] dch(input logic [3:0] d);
    return CH_ZERO | {4'b0, d};
  endfunction

  always_comb begin
    ch = CH_ZERO;
    case (pos_r)
      5'd0, 5'd21: ch = CH_ESC;
      5'd1, 5'd22: ch = CH_LBR;
      5'd18, 5'd24: ch = CH_M;
      5'd19, 5'd20: ch = CH_SPACE;
      5'd23: ch = CH_ZERO;
      5'd25: ch = cmd_r.frame_end ? CH_NUL : CH_NL;
      default: begin
        if (cmd_r.opaque) begin
          case (pos_r)
            5'd2:  ch = CH_FOUR;
            5'd3:  ch = CH_EIGHT;
            5'd5:  ch = CH_TWO;
            5'd4, 5'd6, 5'd10, 5'd14: ch = CH_SEMI;
            5'd7:  ch = dch(cmd_r.digits[0]);
            5'd8:  ch = dch(cmd_r.digits[1]);
            5'd9:  ch = dch(cmd_r.digits[2]);
            5'd11: ch = dch(cmd_r.digits[3]);
            5'd12: ch = dch(cmd_r.digits[4]);
            5'd13: ch = dch(cmd_r.digits[5]);
            5'd15: ch = dch(cmd_r.digits[6]);
            5'd16: ch = dch(cmd_r.digits[7]);
            5'd17: ch = dch(cmd_r.digits[8]);
            default: ch = CH_ZERO;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_r <= 1'b1;
        pos_r       <= '0;
      end else if (emit) begin
        if (last) cur_valid_r <= 1'b0;
        pos_r <= pos_r + POS_W'(1);
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= pop_cmd;
    if (emit) begin
      out_r.out_byte      <= ch;
      out_r.last_of_pixel <= last;
      out_r.end_of_frame  <= last && cmd_r.line_end && cmd_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.end_of_frame |-> out_r.last_of_pixel)
    else $error("end_of_frame without last_of_pixel");
  a_eof_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.end_of_frame |-> out_r.out_byte == CH_NUL)
    else $error("end_of_frame on a nonzero byte");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> pos_r <= POS_LINE_LAST)
    else $error("byte position past the line tail");
`endif

endmodule
